FILE: rtl/core/wall_texel_address_generator_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef WALL_TEXEL_ADDRESS_GENERATOR_MACROS_SVH
`define WALL_TEXEL_ADDRESS_GENERATOR_MACROS_SVH

// same-cycle implication
`define WTAG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication on the next cycle
`define WTAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/wtag_pkg.sv
package wtag_pkg;

  // field widths
  localparam int HIT_W      = 24;
  localparam int SIDE_W     = 3;
  localparam int SEL_W      = 2;
  localparam int WH_W       = 16;
  localparam int PR_W       = 16;
  localparam int TEX_W      = 11;
  localparam int IDX_W      = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_SIDES  = 4;
  localparam int FRAC_BITS  = 8;
  localparam int HH_W       = HIT_W - FRAC_BITS;

  // defaults
  localparam int SCREEN_HEIGHT_DEF = 512;
  localparam int TILE_SIZE_DEF     = 64;
  localparam logic [TEX_W-1:0] TEX_RESET = TEX_W'(64);

  // side codes
  localparam logic [SIDE_W-1:0] SIDE_NORTH = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_SOUTH = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_WEST  = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_EAST  = 3'd3;

  // register index = {side, height flag}
  localparam int CFG_HEIGHT_BIT = 0;

  // row numerator 2*row - H + wh, and its product with the texture height
  localparam int N1_W    = 19;
  localparam int N2_W    = N1_W + TEX_W + 1;
  // divider: quotient magnitude and divisor 2*wh
  localparam int Q_W     = 28;
  localparam int D_W     = WH_W + 1;
  localparam int ROW_W   = Q_W + 1;
  localparam int AREA_W  = 2 * TEX_W;
  localparam int A_W     = ROW_W + TEX_W + 1;
  localparam int FRAC_LAT = 5;

  typedef struct packed {
    logic               vld;
    logic               neg;
    logic [D_W-1:0]     d;
    logic [D_W+Q_W-1:0] rq;   // partial remainder above, numerator / quotient below
  } div_t;

  typedef struct packed {
    logic              bad;
    logic [SEL_W-1:0]  sel;
    logic [TEX_W-1:0]  tw;
    logic [AREA_W-1:0] area;
    logic              wz;
    logic              pr_lt;
  } sb_t;

endpackage

FILE: rtl/core/wtag_div_cell.sv
module wtag_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  wtag_pkg::div_t cell_i,
  output wtag_pkg::div_t cell_o
);
  import wtag_pkg::*;

  div_t           cell_r;
  logic [D_W:0]   top;
  logic [D_W:0]   diff;
  logic           ge;
  logic [D_W-1:0] rem;

  // one restoring step: bring down the next numerator bit, try the divisor
  always_comb begin
    top  = cell_i.rq[D_W+Q_W-1:Q_W-1];
    diff = top - {1'b0, cell_i.d};
    ge   = top >= {1'b0, cell_i.d};
    rem  = ge ? diff[D_W-1:0] : top[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else begin
      cell_r.vld <= cell_i.vld;
    end
    cell_r.neg <= cell_i.neg;
    cell_r.d   <= cell_i.d;
    cell_r.rq  <= {rem, cell_i.rq[Q_W-2:0], ge};
  end

  assign cell_o = cell_r;

endmodule

FILE: rtl/core/wtag_frac.sv
module wtag_frac #(
  parameter int TILE_SIZE = wtag_pkg::TILE_SIZE_DEF
) (
  input  logic                         clk,
  input  logic [wtag_pkg::HH_W-1:0]    hh_i,
  input  logic [wtag_pkg::FRAC_BITS-1:0] lo8_i,
  input  logic [wtag_pkg::TEX_W-1:0]   tw_i,
  output logic [wtag_pkg::TEX_W-1:0]   lo_o,
  output logic [wtag_pkg::TEX_W-1:0]   hi_o
);
  import wtag_pkg::*;

  localparam int LOG_T = $clog2(TILE_SIZE);
  localparam int MH_W  = (LOG_T > 0) ? LOG_T : 1;
  localparam int M_W   = MH_W + FRAC_BITS;
  localparam int F_W   = M_W + TEX_W;
  localparam int X_W   = F_W - FRAC_BITS;
  // exact reciprocals: ceil(2^S / T) with S = width + ceil(log2 T)
  localparam int S_H   = HH_W + LOG_T;
  localparam int S_F   = X_W + LOG_T;
  localparam logic [63:0] RH_FULL = ((64'd1 << S_H) + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE);
  localparam logic [63:0] RF_FULL = ((64'd1 << S_F) + 64'(TILE_SIZE) - 64'd1) / 64'(TILE_SIZE);
  localparam logic [HH_W:0] R_H  = RH_FULL[HH_W:0];
  localparam logic [X_W:0]  R_F  = RF_FULL[X_W:0];
  localparam logic [F_W-1:0] D_M1 = F_W'(TILE_SIZE * 256 - 1);

  logic [2*HH_W:0]      ph;
  logic [HH_W-1:0]      qh_nxt, qh_r, hh_a_r;
  logic [FRAC_BITS-1:0] lo8_a_r;
  logic [TEX_W-1:0]     tw_a_r, tw_b_r;
  logic [HH_W-1:0]      mh_full;
  logic [M_W-1:0]       m_nxt, m_r;
  logic [F_W-1:0]       f_r, fc;
  logic [X_W-1:0]       xlo_r, xhi_r;
  logic [2*X_W:0]       plo, phi;
  logic [TEX_W-1:0]     lo_r, hi_r;

  always_comb begin
    ph      = hh_i * R_H;
    qh_nxt  = HH_W'(ph >> S_H);
    mh_full = hh_a_r - HH_W'(qh_r * TILE_SIZE);
    m_nxt   = {mh_full[MH_W-1:0], lo8_a_r};
    fc      = f_r + D_M1;
    plo     = xlo_r * R_F;
    phi     = xhi_r * R_F;
  end

  // floor and ceiling of m*tw over the tile size in raw units
  always_ff @(posedge clk) begin
    qh_r    <= qh_nxt;
    hh_a_r  <= hh_i;
    lo8_a_r <= lo8_i;
    tw_a_r  <= tw_i;
    m_r     <= m_nxt;
    tw_b_r  <= tw_a_r;
    f_r     <= m_r * tw_b_r;
    xlo_r   <= f_r[F_W-1:FRAC_BITS];
    xhi_r   <= fc[F_W-1:FRAC_BITS];
    lo_r    <= TEX_W'(plo >> S_F);
    hi_r    <= TEX_W'(phi >> S_F);
  end

  assign lo_o = lo_r;
  assign hi_o = hi_r;

endmodule

FILE: rtl/core/wtag_delay.sv
module wtag_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  import wtag_pkg::*;

  logic [W-1:0] line_r [DEPTH];

  always_ff @(posedge clk) begin
    line_r[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      line_r[k] <= line_r[k-1];
    end
  end

  assign q_o = line_r[DEPTH-1];

endmodule

FILE: rtl/core/wall_texel_address_generator.sv
// one word accepted every cycle; busy never rises
// results pass through the 28-cell divider chain for the texture row plus seven stages around it
// the strobe lasts one cycle and the receiver cannot hold it off
// reset (synchronous) empties the pipe and sets every texture size to 64
`include "wall_texel_address_generator_macros.svh"

module wall_texel_address_generator #(
  parameter int SCREEN_HEIGHT = wtag_pkg::SCREEN_HEIGHT_DEF,
  parameter int TILE_SIZE     = wtag_pkg::TILE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [wtag_pkg::HIT_W-1:0]          in_hit_x,
  input  logic [wtag_pkg::HIT_W-1:0]          in_hit_y,
  input  logic [wtag_pkg::SIDE_W-1:0]         in_side,
  input  logic [wtag_pkg::WH_W-1:0]           in_wall_px,
  input  logic signed [wtag_pkg::PR_W-1:0]    in_pixel_row,
  output logic                                out_strobe,
  output logic [wtag_pkg::SEL_W-1:0]          out_tex_select,
  output logic signed [wtag_pkg::IDX_W-1:0]   out_texel_index,
  output logic                                out_in_range,
  output logic                                out_bad_side,
  input  logic                                cfg_we,
  input  logic [wtag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wtag_pkg::TEX_W-1:0]          cfg_data
);
  import wtag_pkg::*;

  localparam int PIPE_LAT = Q_W + 7;
  localparam int FR_DLY   = Q_W + 2 - FRAC_LAT;
  localparam logic signed [N1_W-1:0] SH_S = N1_W'(SCREEN_HEIGHT);

  // texture sizes, one width and one height per orientation
  logic [TEX_W-1:0] tw_r [NUM_SIDES];
  logic [TEX_W-1:0] th_r [NUM_SIDES];

  // stage 1
  logic                    v1_r;
  logic                    bad1_r, wz1_r, prlt1_r;
  logic [SEL_W-1:0]        sel1_r;
  logic [TEX_W-1:0]        tw1_r, th1_r;
  logic [WH_W-1:0]         wh1_r;
  logic signed [N1_W-1:0]  n1_nxt, n1_r;
  logic [HH_W-1:0]         hh1_r;
  logic [FRAC_BITS-1:0]    lo8_1_r;
  logic [HIT_W-1:0]        coord;
  logic                    accept;
  // stage 2
  logic                    v2_r;
  logic signed [N2_W-1:0]  n2_r;
  logic [D_W-1:0]          d2_r;
  sb_t                     sb2_r;
  // stage 3, head of the divider chain
  div_t                    div3_r;
  sb_t                     sb3_r;
  logic [Q_W-1:0]          mag_nxt;
  div_t                    chain [Q_W+1];
  // after the chain
  sb_t                     sb_dly;
  logic [2*TEX_W-1:0]      fr_dly;
  logic [TEX_W-1:0]        frac_lo, frac_hi;
  logic [Q_W-1:0]          quo;
  logic signed [ROW_W-1:0] row_nxt, row_d_r;
  logic                    v_d_r, v_e_r, v_f_r;
  sb_t                     sb_d_r, sb_e_r, sb_f_r;
  logic [TEX_W-1:0]        lo_d_r, hi_d_r, lo_e_r, hi_e_r;
  logic signed [A_W-1:0]   a_e_r, s_lo, s_hi, idx_f_r;
  // output stage
  logic                    ovf, rng_nxt;
  logic [IDX_W-1:0]        sat_nxt;
  logic                    out_strobe_r, out_rng_r, out_bad_r;
  logic [SEL_W-1:0]        out_sel_r;
  logic [IDX_W-1:0]        out_idx_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SIDES; k++) begin
        tw_r[k] <= TEX_RESET;
        th_r[k] <= TEX_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index[CFG_HEIGHT_BIT]) begin
        th_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
      end else begin
        tw_r[cfg_index[CFG_IDX_W-1:1]] <= cfg_data;
      end
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v_d_r        <= 1'b0;
      v_e_r        <= 1'b0;
      v_f_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= accept;
      v2_r         <= v1_r;
      v_d_r        <= chain[Q_W].vld;
      v_e_r        <= v_d_r;
      v_f_r        <= v_e_r;
      out_strobe_r <= v_f_r;
    end
  end

  always_comb begin
    coord  = (in_side < SIDE_WEST) ? in_hit_x : in_hit_y;
    n1_nxt = $signed({{(N1_W-PR_W-1){in_pixel_row[PR_W-1]}}, in_pixel_row, 1'b0}) - SH_S
             + $signed({{(N1_W-WH_W){1'b0}}, in_wall_px});
    mag_nxt = n2_r[N2_W-1] ? Q_W'(-n2_r) : Q_W'(n2_r);
  end

  always_ff @(posedge clk) begin
    // stage 1: pick the texture, form the row numerator
    bad1_r  <= in_side > SIDE_EAST;
    sel1_r  <= in_side[SEL_W-1:0];
    tw1_r   <= tw_r[in_side[SEL_W-1:0]];
    th1_r   <= th_r[in_side[SEL_W-1:0]];
    wh1_r   <= in_wall_px;
    wz1_r   <= in_wall_px == '0;
    prlt1_r <= $signed({{(N1_W-PR_W){in_pixel_row[PR_W-1]}}, in_pixel_row}) < SH_S;
    n1_r    <= n1_nxt;
    hh1_r   <= coord[HIT_W-1:FRAC_BITS];
    lo8_1_r <= coord[FRAC_BITS-1:0];
    // stage 2
    n2_r        <= n1_r * $signed({1'b0, th1_r});
    d2_r        <= {wh1_r, 1'b0};
    sb2_r.bad   <= bad1_r;
    sb2_r.sel   <= sel1_r;
    sb2_r.tw    <= tw1_r;
    sb2_r.area  <= tw1_r * th1_r;
    sb2_r.wz    <= wz1_r;
    sb2_r.pr_lt <= prlt1_r;
    // stage 3: sign and magnitude into the chain
    if (!rst_n) begin
      div3_r.vld <= 1'b0;
    end else begin
      div3_r.vld <= v2_r;
    end
    div3_r.neg <= n2_r[N2_W-1];
    div3_r.d   <= d2_r;
    div3_r.rq  <= {{D_W{1'b0}}, mag_nxt};
    sb3_r      <= sb2_r;
  end

  assign chain[0] = div3_r;

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    wtag_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  wtag_frac #(
    .TILE_SIZE (TILE_SIZE)
  ) u_frac (
    .clk   (clk),
    .hh_i  (hh1_r),
    .lo8_i (lo8_1_r),
    .tw_i  (tw1_r),
    .lo_o  (frac_lo),
    .hi_o  (frac_hi)
  );

  wtag_delay #(
    .W     ($bits(sb_t)),
    .DEPTH (Q_W)
  ) u_sb_dly (
    .clk (clk),
    .d_i (sb3_r),
    .q_o (sb_dly)
  );

  wtag_delay #(
    .W     (2 * TEX_W),
    .DEPTH (FR_DLY)
  ) u_fr_dly (
    .clk (clk),
    .d_i ({frac_lo, frac_hi}),
    .q_o (fr_dly)
  );

  always_comb begin
    quo     = chain[Q_W].rq[Q_W-1:0];
    row_nxt = $signed({1'b0, quo});
    if (chain[Q_W].neg) begin
      row_nxt = -row_nxt;
    end
    // a zero-height wall gives row zero whatever the chain says
    if (sb_dly.wz) begin
      row_nxt = '0;
    end
    s_lo = a_e_r + $signed({{(A_W-TEX_W){1'b0}}, lo_e_r});
    s_hi = a_e_r + $signed({{(A_W-TEX_W){1'b0}}, hi_e_r});
    // top bits not all alike: index does not fit the output
    ovf  = (|idx_f_r[A_W-1:IDX_W-1]) && !(&idx_f_r[A_W-1:IDX_W-1]);
    if (ovf) begin
      sat_nxt = idx_f_r[A_W-1] ? {1'b1, {(IDX_W-1){1'b0}}} : {1'b0, {(IDX_W-1){1'b1}}};
    end else begin
      sat_nxt = idx_f_r[IDX_W-1:0];
    end
    rng_nxt = !sb_f_r.bad && !sb_f_r.wz && sb_f_r.pr_lt && !idx_f_r[A_W-1]
              && ($unsigned(idx_f_r) < {{(A_W-AREA_W){1'b0}}, sb_f_r.area});
  end

  always_ff @(posedge clk) begin
    row_d_r <= row_nxt;
    sb_d_r  <= sb_dly;
    lo_d_r  <= fr_dly[2*TEX_W-1:TEX_W];
    hi_d_r  <= fr_dly[TEX_W-1:0];
    a_e_r   <= row_d_r * $signed({1'b0, sb_d_r.tw});
    sb_e_r  <= sb_d_r;
    lo_e_r  <= lo_d_r;
    hi_e_r  <= hi_d_r;
    // a non-negative floor sum means the numerator was non-negative, else round up
    idx_f_r <= s_lo[A_W-1] ? s_hi : s_lo;
    sb_f_r  <= sb_e_r;
    out_sel_r <= sb_f_r.bad ? '0 : sb_f_r.sel;
    out_idx_r <= sb_f_r.bad ? '0 : sat_nxt;
    out_rng_r <= rng_nxt;
    out_bad_r <= sb_f_r.bad;
  end

  assign out_strobe      = out_strobe_r;
  assign out_tex_select  = out_sel_r;
  assign out_texel_index = out_idx_r;
  assign out_in_range    = out_rng_r;
  assign out_bad_side    = out_bad_r;

  `WTAG_ASSERT_IMP(a_strobe_has_source, out_strobe,
                   $past(start && !busy, PIPE_LAT), "result word without a start")
  `WTAG_ASSERT_IMP(a_bad_side_zeroed, out_strobe && out_bad_side,
                   (out_tex_select == '0) && (out_texel_index == '0) && !out_in_range,
                   "bad side word not cleared")
  `WTAG_ASSERT_IMP(a_in_range_nonneg, out_strobe && out_in_range,
                   !out_texel_index[IDX_W-1], "in range with negative index")
  `WTAG_ASSERT_NEXT(a_zero_height_out, v_f_r && !sb_f_r.bad && sb_f_r.wz,
                    !out_in_range, "zero wall height marked in range")

endmodule
